// ===== rtl/mains_loss_duty_detector_assert.svh =====
// Assertion macros for the mains loss duty detector.
// Define NO_ASSERTIONS to compile them out; needs clk and rst_n in scope.
`ifndef MAINS_LOSS_DUTY_DETECTOR_ASSERT_SVH
`define MAINS_LOSS_DUTY_DETECTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MLD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mld assertion failed");
// next-cycle implication
`define MLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mld assertion failed");
`else
`define MLD_ASSERT_NOW(label, ante, cons)
`define MLD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/mld_pkg.sv =====
// Shared types and constants for the mains loss duty detector.
// No dependencies.
package mld_pkg;

  localparam int TICK_BITS = 16;
  localparam int DUTY_BITS = 20;
  localparam int DEB_BITS  = 16;
  localparam int CONF_BITS = 8;
  localparam int CFG_BITS  = 20;

  localparam logic [DUTY_BITS-1:0] PPM_SCALE       = 20'd1000000;
  localparam logic [CONF_BITS-1:0] CONFIRM_DEFAULT = 8'd3;
  localparam logic [CONF_BITS-1:0] AGREE_MAX       = 8'hFF;

  // supply type codes
  localparam logic [1:0] TYPE_ONE     = 2'd0;
  localparam logic [1:0] TYPE_TWO     = 2'd1;
  localparam logic [1:0] TYPE_UNKNOWN = 2'd2;

  // event mode bits
  localparam int MODE_CAPTURE_BIT = 0;
  localparam int MODE_TIMEOUT_BIT = 1;

  // register indexes
  localparam logic [1:0] CFG_DUTY_PPM       = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_CONFIRM_LIMIT  = 2'd2;
  localparam logic [1:0] CFG_PRINT_ACTIVE   = 2'd3;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty_ppm;
    logic [DEB_BITS-1:0]  debounce_limit;
    logic [CONF_BITS-1:0] confirm_limit;
    logic                 print_active;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [TICK_BITS-1:0] interval_ticks;
    logic                 pin_level;
    logic                 save_done;
  } in_item_t;

  typedef struct packed {
    logic                 loss_flag;
    logic                 save_request;
    logic [1:0]           supply_type;
    logic [TICK_BITS-1:0] high_time;
    logic                 high_known;
    logic [TICK_BITS-1:0] low_time;
    logic                 low_known;
    logic                 armed;
  } out_item_t;

  // handshake between input register and output stage
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

// ===== rtl/mains_loss_duty_detector.sv =====
// Top level of the mains loss duty detector: config registers, input
// stage, state update and result register. Uses mld_pkg, mld_in_reg, mld_core.
//
//   port group | direction | flow
//   in_*       | request   | in_valid / in_stall, payload in_data
//   out_*      | result    | out_valid / out_stall, payload out_data
//   cfg_*      | write     | cfg_we, cfg_index, cfg_wdata, no wait
//
// One request per cycle unless stalled; each passes input then result register.
// The state update is one pass: a 17x20 multiply and a compare against the
// high time times 1e6, between the input register and the result register.
// Synchronous active-low reset; config returns to its documented defaults.
// A stalled result holds; one more request is still taken into the input stage.
`include "mains_loss_duty_detector_assert.svh"
module mains_loss_duty_detector (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  mld_pkg::in_item_t       in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output mld_pkg::out_item_t      out_data,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [mld_pkg::CFG_BITS-1:0] cfg_wdata
);
  import mld_pkg::*;

  cfg_t       cfg_r;
  in_item_t   s1_data;
  logic       s1_valid;
  logic       advance;
  stage_ctl_t ctl;
  out_item_t  result;
  out_item_t  out_data_r;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_ppm       <= 20'd500000;
      cfg_r.debounce_limit <= '0;
      cfg_r.confirm_limit  <= CONFIRM_DEFAULT;
      cfg_r.print_active   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DUTY_PPM:       cfg_r.duty_ppm       <= cfg_wdata[DUTY_BITS-1:0];
        CFG_DEBOUNCE_LIMIT: cfg_r.debounce_limit <= cfg_wdata[DEB_BITS-1:0];
        CFG_CONFIRM_LIMIT:  cfg_r.confirm_limit  <= cfg_wdata[CONF_BITS-1:0];
        CFG_PRINT_ACTIVE:   cfg_r.print_active   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // output register frees up when empty or taken
  assign advance = !out_valid_r || !out_stall;

  mld_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .s1_data  (s1_data),
    .s1_valid (s1_valid)
  );

  assign ctl.valid   = s1_valid;
  assign ctl.advance = advance;

  mld_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .item   (s1_data),
    .cfg    (cfg_r),
    .result (result)
  );

  assign out_valid_nxt = advance ? s1_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MLD_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid)
  `MLD_ASSERT_NEXT(a_item_moves_out, s1_valid && advance, out_valid_r)
  `MLD_ASSERT_NOW(a_request_has_loss, out_valid_r && out_data_r.save_request,
                  out_data_r.loss_flag)
endmodule

// ===== rtl/mld_in_reg.sv =====
// Input register stage of the mains loss duty detector.
// Uses mld_pkg; holds one request while the output stage is busy.
module mld_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mld_pkg::in_item_t in_data,
  input  logic              advance,
  output mld_pkg::in_item_t s1_data,
  output logic              s1_valid
);
  import mld_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t data_r;
  logic     take;

  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_data;
    end
  end

  assign s1_data  = data_r;
  assign s1_valid = valid_r;
endmodule

// ===== rtl/mld_core.sv =====
// Detector state and its single-pass update: debounce, phase capture,
// duty classification with confirmation, loss latch. Uses mld_pkg.
module mld_core (
  input  logic                clk,
  input  logic                rst_n,
  input  mld_pkg::stage_ctl_t ctl,
  input  mld_pkg::in_item_t   item,
  input  mld_pkg::cfg_t       cfg,
  output mld_pkg::out_item_t  result
);
  import mld_pkg::*;

  localparam int SUM_W  = TICK_BITS + 1;
  localparam int PROD_W = SUM_W + DUTY_BITS;

  logic [DEB_BITS-1:0]  deb_cnt_r, deb_cnt_nxt;
  logic [TICK_BITS-1:0] high_r, high_nxt;
  logic                 high_vld_r, high_vld_nxt;
  logic [TICK_BITS-1:0] low_r, low_nxt;
  logic                 low_vld_r, low_vld_nxt;
  logic [1:0]           cand_r, cand_nxt;
  logic [1:0]           conf_r, conf_nxt;
  logic [CONF_BITS-1:0] agree_r, agree_nxt;
  logic                 loss_r, loss_nxt;
  logic                 request;

  logic [SUM_W-1:0]     period;
  logic [PROD_W-1:0]    thr_prod;
  logic [PROD_W-1:0]    high_prod;
  logic [1:0]           kind;
  logic [CONF_BITS-1:0] need;
  logic                 update;

  assign update = ctl.valid && ctl.advance;

  // high > floor(P*duty/1e6) is the same as P*duty < high*1e6
  assign period    = SUM_W'(high_r) + SUM_W'(item.interval_ticks);
  assign thr_prod  = PROD_W'(period) * PROD_W'(cfg.duty_ppm);
  assign high_prod = PROD_W'(high_r) * PROD_W'(PPM_SCALE);
  assign kind      = (thr_prod < high_prod) ? TYPE_TWO : TYPE_ONE;
  assign need      = (cfg.confirm_limit == '0) ? CONFIRM_DEFAULT : cfg.confirm_limit;

  always_comb begin
    deb_cnt_nxt  = deb_cnt_r;
    high_nxt     = high_r;
    high_vld_nxt = high_vld_r;
    low_nxt      = low_r;
    low_vld_nxt  = low_vld_r;
    cand_nxt     = cand_r;
    conf_nxt     = conf_r;
    agree_nxt    = agree_r;
    loss_nxt     = loss_r;
    request      = 1'b0;
    if (item.mode != 2'b00) begin
      if (deb_cnt_r < cfg.debounce_limit) begin
        deb_cnt_nxt = deb_cnt_r + 1'b1;
        loss_nxt    = 1'b0;
      end else begin
        if (item.mode[MODE_CAPTURE_BIT]) begin
          if (item.pin_level) begin
            low_nxt     = item.interval_ticks;
            low_vld_nxt = 1'b1;
            if (high_vld_r) begin
              if (kind == cand_r) begin
                if (agree_r < AGREE_MAX) begin
                  agree_nxt = agree_r + 1'b1;
                end
              end else begin
                cand_nxt  = kind;
                agree_nxt = CONF_BITS'(1);
              end
              if (agree_nxt >= need) begin
                conf_nxt = cand_nxt;
              end
            end
          end else begin
            high_nxt     = item.interval_ticks;
            high_vld_nxt = 1'b1;
          end
        end
        if (item.mode[MODE_TIMEOUT_BIT] && !loss_r && cfg.print_active &&
            !item.save_done) begin
          loss_nxt = 1'b1;
          request  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_cnt_r  <= '0;
      high_r     <= '0;
      high_vld_r <= 1'b0;
      low_r      <= '0;
      low_vld_r  <= 1'b0;
      cand_r     <= TYPE_UNKNOWN;
      conf_r     <= TYPE_UNKNOWN;
      agree_r    <= '0;
      loss_r     <= 1'b0;
    end else if (update) begin
      deb_cnt_r  <= deb_cnt_nxt;
      high_r     <= high_nxt;
      high_vld_r <= high_vld_nxt;
      low_r      <= low_nxt;
      low_vld_r  <= low_vld_nxt;
      cand_r     <= cand_nxt;
      conf_r     <= conf_nxt;
      agree_r    <= agree_nxt;
      loss_r     <= loss_nxt;
    end
  end

  always_comb begin
    result.loss_flag    = loss_nxt;
    result.save_request = request;
    result.supply_type  = conf_nxt;
    result.high_time    = high_nxt;
    result.high_known   = high_vld_nxt;
    result.low_time     = low_nxt;
    result.low_known    = low_vld_nxt;
    result.armed        = (deb_cnt_nxt >= cfg.debounce_limit);
  end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for mains_loss_duty_detector: timer events in, one status per event out.
// Keeps its own copy of detector state and registers to predict each status; needs mld_pkg.
module tb;
  import mld_pkg::*;

  localparam logic [1:0] EV_NONE    = 2'b00;
  localparam logic [1:0] EV_CAPTURE = 2'(1 << MODE_CAPTURE_BIT);
  localparam logic [1:0] EV_TIMEOUT = 2'(1 << MODE_TIMEOUT_BIT);
  localparam logic [1:0] EV_BOTH    = EV_CAPTURE | EV_TIMEOUT;
  localparam int         SQUEEZE_CYCLES = 300;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = CFG_DUTY_PPM;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  // register copies, at their reset values
  logic [DUTY_BITS-1:0] duty_cfg     = 20'd500000;
  logic [DEB_BITS-1:0]  debounce_cfg = '0;
  logic [CONF_BITS-1:0] confirm_cfg  = 8'd3;
  logic                 printing_cfg = 1'b0;

  // detector state copy
  logic [DEB_BITS-1:0]  settle_count = '0;
  logic [TICK_BITS-1:0] high_len     = '0;
  logic                 high_seen    = 1'b0;
  logic [TICK_BITS-1:0] low_len      = '0;
  logic                 low_seen     = 1'b0;
  logic [1:0]           trial_type   = TYPE_UNKNOWN;
  logic [1:0]           supply_now   = TYPE_UNKNOWN;
  logic [CONF_BITS-1:0] agree_run    = '0;
  logic                 loss_held    = 1'b0;

  in_item_t  pending_events[$];
  out_item_t expected_status[$];
  int        mismatches = 0;
  int        send_wait = 0;
  int        hold_cycles = 0;
  logic      quiet_mode = 1'b0;
  logic      squeeze_armed = 1'b0;
  logic      squeeze_done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mains_loss_duty_detector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Advance the detector copy by one event and return the status it reports.
  function automatic out_item_t detector_step(in_item_t ev);
    out_item_t            st;
    logic [63:0]          period;
    logic [63:0]          limit;
    logic [1:0]           kind;
    logic [CONF_BITS-1:0] need;
    st = '0;
    if (ev.mode != EV_NONE) begin
      if (settle_count < debounce_cfg) begin
        settle_count = settle_count + 1'b1;
        loss_held = 1'b0;
      end else begin
        if (ev.mode[MODE_CAPTURE_BIT]) begin
          if (ev.pin_level) begin
            low_len = ev.interval_ticks;
            low_seen = 1'b1;
            if (high_seen) begin
              period = 64'(high_len) + 64'(low_len);
              limit = (period * 64'(duty_cfg)) / 64'(PPM_SCALE);
              kind = (64'(high_len) > limit) ? TYPE_TWO : TYPE_ONE;
              need = (confirm_cfg != '0) ? confirm_cfg : CONFIRM_DEFAULT;
              if (kind == trial_type) begin
                if (agree_run < AGREE_MAX) agree_run = agree_run + 1'b1;
              end else begin
                trial_type = kind;
                agree_run = 8'd1;
              end
              if (agree_run >= need) supply_now = trial_type;
            end
          end else begin
            high_len = ev.interval_ticks;
            high_seen = 1'b1;
          end
        end
        if (ev.mode[MODE_TIMEOUT_BIT] && !loss_held && printing_cfg && !ev.save_done) begin
          loss_held = 1'b1;
          st.save_request = 1'b1;
        end
      end
    end
    st.loss_flag   = loss_held;
    st.supply_type = supply_now;
    st.high_time   = high_len;
    st.high_known  = high_seen;
    st.low_time    = low_len;
    st.low_known   = low_seen;
    st.armed       = (settle_count >= debounce_cfg);
    return st;
  endfunction

  function automatic void check_field(string name, logic [TICK_BITS-1:0] want,
                                      logic [TICK_BITS-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void queue_event(logic [1:0] mode, longint ticks, logic level,
                                      logic saved);
    in_item_t ev;
    ev.mode           = mode;
    ev.interval_ticks = TICK_BITS'(ticks);
    ev.pin_level      = level;
    ev.save_done      = saved;
    pending_events.push_back(ev);
  endfunction

  // high phase capture, then the capture that ends the low phase
  function automatic void queue_cycle(longint hi, longint lo, logic [1:0] end_mode);
    queue_event(EV_CAPTURE, hi, 1'b0, 1'($urandom_range(0, 1)));
    queue_event(end_mode, lo, 1'b1, 1'($urandom_range(0, 1)));
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_DUTY_PPM:       duty_cfg = value[DUTY_BITS-1:0];
      CFG_DEBOUNCE_LIMIT: debounce_cfg = value[DEB_BITS-1:0];
      CFG_CONFIRM_LIMIT:  confirm_cfg = value[CONF_BITS-1:0];
      CFG_PRINT_ACTIVE:   printing_cfg = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_status.size() != 0);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_status.push_back(detector_step(in_data));
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        in_data   <= pending_events.pop_front();
        in_valid  <= 1'b1;
        send_wait = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure, including one long hold-off
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (squeeze_armed && !squeeze_done) begin
      squeeze_done = 1'b1;
      hold_cycles = SQUEEZE_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (quiet_mode) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        hold_cycles = (r < 93) ? $urandom_range(0, 2) : $urandom_range(8, 30);
      end
    end
  end

  // status checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: status %0h with no request outstanding", $time, out_data);
      end else begin
        want = expected_status.pop_front();
        check_field("loss_flag", want.loss_flag, out_data.loss_flag);
        check_field("save_request", want.save_request, out_data.save_request);
        check_field("supply_type", want.supply_type, out_data.supply_type);
        check_field("high_time", want.high_time, out_data.high_time);
        check_field("high_known", want.high_known, out_data.high_known);
        check_field("low_time", want.low_time, out_data.low_time);
        check_field("low_known", want.low_known, out_data.low_known);
        check_field("armed", want.armed, out_data.armed);
      end
    end
  end

  initial begin
    longint duty;
    longint deb;
    longint hi;
    longint lo;
    int     r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: no loss flagging, armed at once, confirm after three
    queue_event(EV_TIMEOUT, 16'h1234, 1'b0, 1'b0);
    queue_event(EV_NONE, 16'hFFFF, 1'b1, 1'b1);
    queue_cycle(0, 0, EV_CAPTURE);
    queue_cycle(16'hFFFF, 16'hFFFF, EV_CAPTURE);
    queue_cycle(16'hFFFF, 0, EV_CAPTURE);
    queue_cycle(16'hFFFF, 1, EV_CAPTURE);
    queue_cycle(16'hFFFF, 1, EV_BOTH);

    // debounce two events, then loss flagging with and without a saved record
    wait_idle();
    write_reg(CFG_PRINT_ACTIVE, 1);
    write_reg(CFG_DEBOUNCE_LIMIT, 2);
    write_reg(CFG_CONFIRM_LIMIT, 1);
    write_reg(CFG_DUTY_PPM, 20'd1000000);
    queue_event(EV_TIMEOUT, 5, 1'b0, 1'b0);
    queue_event(EV_CAPTURE, 9, 1'b1, 1'b0);
    queue_event(EV_TIMEOUT, 0, 1'b0, 1'b1);
    queue_event(EV_TIMEOUT, 0, 1'b0, 1'b0);
    queue_event(EV_TIMEOUT, 0, 1'b1, 1'b0);
    queue_event(EV_BOTH, 100, 1'b1, 1'b0);

    // largest debounce limit clears the loss flag; duty above one million
    wait_idle();
    write_reg(CFG_DEBOUNCE_LIMIT, 16'hFFFF);
    write_reg(CFG_CONFIRM_LIMIT, 0);
    write_reg(CFG_DUTY_PPM, 20'hFFFFF);
    queue_event(EV_TIMEOUT, 3, 1'b0, 1'b0);
    queue_event(EV_CAPTURE, 3, 1'b1, 1'b0);

    // limit dropped below the count arms at once
    wait_idle();
    write_reg(CFG_DEBOUNCE_LIMIT, 0);
    queue_cycle(16'hFFFF, 10, EV_CAPTURE);
    queue_event(EV_TIMEOUT, 0, 1'b0, 1'b0);

    // zero duty, widest confirm window, printing off
    wait_idle();
    write_reg(CFG_DUTY_PPM, 0);
    write_reg(CFG_CONFIRM_LIMIT, 8'hFF);
    write_reg(CFG_PRINT_ACTIVE, 0);
    queue_cycle(1, 16'hFFFF, EV_CAPTURE);
    queue_cycle(0, 5, EV_BOTH);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      r = $urandom_range(0, 3);
      duty = (r == 0) ? 0 : (r == 1) ? 1000000 : (r == 2) ? 20'hFFFFF : $urandom_range(0, 1000000);
      write_reg(CFG_DUTY_PPM, CFG_BITS'(duty));
      r = $urandom_range(0, 9);
      if (r == 0) deb = 0;
      else if (r == 1 && ph > 4) deb = 16'hFFFF;
      else deb = longint'(settle_count) + $urandom_range(0, 3);
      if (deb > 16'hFFFF) deb = 16'hFFFF;
      write_reg(CFG_DEBOUNCE_LIMIT, CFG_BITS'(deb));
      r = $urandom_range(0, 3);
      write_reg(CFG_CONFIRM_LIMIT,
                CFG_BITS'((r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 8'hFF :
                          $urandom_range(1, 6)));
      write_reg(CFG_PRINT_ACTIVE, CFG_BITS'($urandom_range(0, 1)));
      quiet_mode = ($urandom_range(0, 3) == 0);
      repeat (12) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          // land the high phase near the duty threshold
          lo = $urandom_range(0, 20000);
          if (duty >= 1000000) hi = $urandom_range(0, 65535);
          else hi = (lo * duty) / (1000000 - duty) + $urandom_range(0, 4) - 2;
          if (hi < 0) hi = 0;
          if (hi > 16'hFFFF) hi = 16'hFFFF;
          queue_cycle(hi, lo, ($urandom_range(0, 4) == 0) ? EV_BOTH : EV_CAPTURE);
        end else if (r < 80) begin
          queue_cycle($urandom_range(0, 65535), $urandom_range(0, 65535),
                      ($urandom_range(0, 4) == 0) ? EV_BOTH : EV_CAPTURE);
        end else begin
          queue_event(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
      if (ph == 2) squeeze_armed = 1'b1;
    end

    // saturate the agreement count: zero high phase keeps every run at type one
    wait_idle();
    write_reg(CFG_DEBOUNCE_LIMIT, CFG_BITS'(settle_count));
    write_reg(CFG_CONFIRM_LIMIT, 8'hFF);
    write_reg(CFG_DUTY_PPM, 20'd500000);
    quiet_mode = 1'b1;
    queue_event(EV_CAPTURE, 0, 1'b0, 1'b0);
    repeat (260)
      queue_event(EV_CAPTURE, $urandom_range(0, 65535), 1'b1, 1'($urandom_range(0, 1)));

    wait_idle();
    quiet_mode = 1'b0;
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
